@@ src/leb_pkg.sv @@
// Shared constants, types and the sequencer program of the line edit buffer.
package leb_pkg;

   localparam int LINE_SIZE = 256;
   localparam int PTR_W     = $clog2(LINE_SIZE);
   localparam int CMP_W     = ((PTR_W > 8) ? PTR_W : 8) + 1;
   localparam int STEP_W    = 4;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [STEP_W-1:0] step_type;

   // Request kinds.
   localparam logic [2:0] KIND_INSERT   = 3'd0;
   localparam logic [2:0] KIND_DELETE   = 3'd1;
   localparam logic [2:0] KIND_FORWARD  = 3'd2;
   localparam logic [2:0] KIND_BACKWARD = 3'd3;
   localparam logic [2:0] KIND_READ     = 3'd4;

   // Program steps.
   localparam step_type S_IDLE      = 4'd0;
   localparam step_type S_DECODE    = 4'd1;
   localparam step_type S_INS_PRIME = 4'd2;
   localparam step_type S_INS_LOOP  = 4'd3;
   localparam step_type S_INS_PUT   = 4'd4;
   localparam step_type S_DEL_PRIME = 4'd5;
   localparam step_type S_DEL_LOOP  = 4'd6;
   localparam step_type S_DEL_FIX   = 4'd7;
   localparam step_type S_FWD       = 4'd8;
   localparam step_type S_BWD       = 4'd9;
   localparam step_type S_RD_ISSUE  = 4'd10;
   localparam step_type S_RD_TAKE   = 4'd11;
   localparam step_type S_RESP      = 4'd12;

   // Pointer operations.
   localparam logic [2:0] PTR_HOLD   = 3'd0;
   localparam logic [2:0] PTR_LD_END = 3'd1;
   localparam logic [2:0] PTR_LD_CUR = 3'd2;
   localparam logic [2:0] PTR_INC    = 3'd3;
   localparam logic [2:0] PTR_DEC    = 3'd4;

   // Store read address selection.
   localparam logic [2:0] RD_END_M1 = 3'd0;
   localparam logic [2:0] RD_PTR_M2 = 3'd1;
   localparam logic [2:0] RD_CUR_N  = 3'd2;
   localparam logic [2:0] RD_PTR_N1 = 3'd3;
   localparam logic [2:0] RD_INDEX  = 3'd4;

   // Store write selection.
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_SHIFT = 2'd1;
   localparam logic [1:0] WR_CHAR  = 2'd2;

   // Register updates.
   localparam logic [2:0] REG_NONE = 3'd0;
   localparam logic [2:0] REG_INS  = 3'd1;
   localparam logic [2:0] REG_DEL  = 3'd2;
   localparam logic [2:0] REG_FWD  = 3'd3;
   localparam logic [2:0] REG_BWD  = 3'd4;
   localparam logic [2:0] REG_TAKE = 3'd5;

   // Jump conditions.
   localparam logic [2:0] C_ALWAYS     = 3'd0;
   localparam logic [2:0] C_REQ        = 3'd1;
   localparam logic [2:0] C_PTR_AT_CUR = 3'd2;
   localparam logic [2:0] C_PTR_N_END  = 3'd3;
   localparam logic [2:0] C_OUT_FREE   = 3'd4;

   typedef struct packed {
      logic       accept;
      logic       dispatch;
      logic       respond;
      logic [2:0] ptr_op;
      logic [2:0] rd_sel;
      logic [1:0] wr_sel;
      logic [2:0] reg_op;
      logic [2:0] cond;
      step_type   target;
   } ctl_word_type;

   // The program. When the condition holds the step counter jumps to the
   // target, otherwise it stays on the same step; decode dispatches instead.
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = '{1'b0, 1'b0, 1'b0, PTR_HOLD, RD_INDEX, WR_NONE, REG_NONE, C_ALWAYS, S_IDLE};
      case (step)
         S_IDLE: begin
            w.accept = 1'b1;
            w.cond   = C_REQ;
            w.target = S_DECODE;
         end
         S_DECODE: begin
            w.dispatch = 1'b1;
         end
         S_INS_PRIME: begin
            w.ptr_op = PTR_LD_END;
            w.rd_sel = RD_END_M1;
            w.target = S_INS_LOOP;
         end
         S_INS_LOOP: begin
            w.ptr_op = PTR_DEC;
            w.rd_sel = RD_PTR_M2;
            w.wr_sel = WR_SHIFT;
            w.cond   = C_PTR_AT_CUR;
            w.target = S_INS_PUT;
         end
         S_INS_PUT: begin
            w.wr_sel = WR_CHAR;
            w.reg_op = REG_INS;
            w.target = S_RESP;
         end
         S_DEL_PRIME: begin
            w.ptr_op = PTR_LD_CUR;
            w.rd_sel = RD_CUR_N;
            w.target = S_DEL_LOOP;
         end
         S_DEL_LOOP: begin
            w.ptr_op = PTR_INC;
            w.rd_sel = RD_PTR_N1;
            w.wr_sel = WR_SHIFT;
            w.cond   = C_PTR_N_END;
            w.target = S_DEL_FIX;
         end
         S_DEL_FIX: begin
            w.reg_op = REG_DEL;
            w.target = S_RESP;
         end
         S_FWD: begin
            w.reg_op = REG_FWD;
            w.target = S_RESP;
         end
         S_BWD: begin
            w.reg_op = REG_BWD;
            w.target = S_RESP;
         end
         S_RD_ISSUE: begin
            w.rd_sel = RD_INDEX;
            w.target = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            w.reg_op = REG_TAKE;
            w.target = S_RESP;
         end
         S_RESP: begin
            w.respond = 1'b1;
            w.cond    = C_OUT_FREE;
            w.target  = S_IDLE;
         end
         default: begin
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/leb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/line_edit_buffer_unit.sv @@
// Line edit buffer: one text line in a character store, run by a microcoded sequencer.
// Every item is taken in the idle step and decoded; a move then updates the cursor, a
// read issues and takes the store read, and an insert or a delete runs its shift loop
// over the tail and then updates the line; a rejected request goes straight from decode
// to the answer step. Only one item is in work at a time; a new one waits for idle.
// Reset (synchronous, active high) clears cursor, line end, step counter and result valid.
module line_edit_buffer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_count,
   input  logic [7:0] req_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic       rsp_beep,
   output logic [7:0] rsp_cursor_pos,
   output logic [7:0] rsp_end_pos,
   output logic [7:0] rsp_read_char
);

   // Sequencer state.
   leb_pkg::step_type     pc_ff, pc_in;
   leb_pkg::ctl_word_type ctl;
   logic                  cond_true;
   leb_pkg::step_type     dispatch_step;

   // Latched request. These are payload registers and need no reset.
   logic [2:0] kind_ff;
   logic [7:0] char_ff;
   logic [7:0] count_ff;
   logic [7:0] index_ff;

   // Line state.
   leb_pkg::ptr_type cursor_ff, cursor_in;
   leb_pkg::ptr_type end_ff, end_in;
   leb_pkg::ptr_type ptr_ff, ptr_in;
   logic             ok_ff, ok;
   logic [7:0]       rc_ff, rc_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff;
   logic [7:0] rsp_cursor_ff;
   logic [7:0] rsp_end_ff;
   logic [7:0] rsp_char_ff;

   // Character store.
   logic             ram_we;
   leb_pkg::ptr_type ram_waddr;
   logic [7:0]       ram_wdata;
   leb_pkg::ptr_type ram_raddr;
   logic [7:0]       ram_rdata;

   // Widened copies so that every compare and address sum is done without wrap.
   leb_pkg::cmp_type cur_x, end_x, ptr_x, n_x, idx_x, tail_x, rd_x;

   logic accept;
   logic out_free;
   logic respond;

   assign ctl = leb_pkg::ucode(pc_ff);

   assign cur_x  = leb_pkg::cmp_type'(cursor_ff);
   assign end_x  = leb_pkg::cmp_type'(end_ff);
   assign ptr_x  = leb_pkg::cmp_type'(ptr_ff);
   assign n_x    = leb_pkg::cmp_type'(count_ff);
   assign idx_x  = leb_pkg::cmp_type'(index_ff);
   assign tail_x = end_x - cur_x;

   assign accept    = ctl.accept & req_valid;
   assign req_stall = ~ctl.accept;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign respond   = ctl.respond & out_free;

   // Jump condition selected by the current control word.
   always_comb begin
      case (ctl.cond)
         leb_pkg::C_ALWAYS:     cond_true = 1'b1;
         leb_pkg::C_REQ:        cond_true = req_valid;
         leb_pkg::C_PTR_AT_CUR: cond_true = (ptr_ff == cursor_ff);
         leb_pkg::C_PTR_N_END:  cond_true = ((ptr_x + n_x) == end_x);
         leb_pkg::C_OUT_FREE:   cond_true = out_free;
         default:               cond_true = 1'b1;
      endcase
   end

   // Bounds check of the latched request. Because the cursor never passes the
   // line end, the tail length cannot underflow.
   always_comb begin
      case (kind_ff)
         leb_pkg::KIND_INSERT:
            ok = (end_x != leb_pkg::cmp_type'(leb_pkg::LINE_SIZE - 1));
         leb_pkg::KIND_DELETE, leb_pkg::KIND_FORWARD:
            ok = (count_ff != 8'd0) && (n_x <= tail_x);
         leb_pkg::KIND_BACKWARD:
            ok = (count_ff != 8'd0) && (n_x <= cur_x);
         leb_pkg::KIND_READ:
            ok = (idx_x < end_x);
         default:
            ok = 1'b0;
      endcase
   end

   // Dispatch table: a rejected request goes straight to the answer step.
   always_comb begin
      if (!ok) begin
         dispatch_step = leb_pkg::S_RESP;
      end else begin
         case (kind_ff)
            leb_pkg::KIND_INSERT:   dispatch_step = leb_pkg::S_INS_PRIME;
            leb_pkg::KIND_DELETE:   dispatch_step = leb_pkg::S_DEL_PRIME;
            leb_pkg::KIND_FORWARD:  dispatch_step = leb_pkg::S_FWD;
            leb_pkg::KIND_BACKWARD: dispatch_step = leb_pkg::S_BWD;
            leb_pkg::KIND_READ:     dispatch_step = leb_pkg::S_RD_ISSUE;
            default:                dispatch_step = leb_pkg::S_RESP;
         endcase
      end
   end

   always_comb begin
      if (ctl.dispatch) begin
         pc_in = dispatch_step;
      end else if (cond_true) begin
         pc_in = ctl.target;
      end else begin
         pc_in = pc_ff;
      end
   end

   // Read address. The shift loops read the source of the next position
   // they write, so that the registered read data is ready when it is written.
   // A read that wraps past either end of the store is never used.
   always_comb begin
      case (ctl.rd_sel)
         leb_pkg::RD_END_M1: rd_x = end_x - leb_pkg::cmp_type'(1);
         leb_pkg::RD_PTR_M2: rd_x = ptr_x - leb_pkg::cmp_type'(2);
         leb_pkg::RD_CUR_N:  rd_x = cur_x + n_x;
         leb_pkg::RD_PTR_N1: rd_x = ptr_x + n_x + leb_pkg::cmp_type'(1);
         leb_pkg::RD_INDEX:  rd_x = idx_x;
         default:            rd_x = idx_x;
      endcase
   end

   assign ram_raddr = rd_x[leb_pkg::PTR_W-1:0];

   // A shift step writes only while the loop has not reached its exit.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = ram_rdata;
      case (ctl.wr_sel)
         leb_pkg::WR_SHIFT: begin
            ram_we = ~cond_true;
         end
         leb_pkg::WR_CHAR: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff;
            ram_wdata = char_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (ctl.ptr_op)
         leb_pkg::PTR_LD_END: ptr_in = end_ff;
         leb_pkg::PTR_LD_CUR: ptr_in = cursor_ff;
         leb_pkg::PTR_INC:    ptr_in = ptr_ff + leb_pkg::ptr_type'(1);
         leb_pkg::PTR_DEC:    ptr_in = ptr_ff - leb_pkg::ptr_type'(1);
         default:             ptr_in = ptr_ff;
      endcase
   end

   // Cursor, line end and read character updates.
   always_comb begin
      cursor_in = cursor_ff;
      end_in    = end_ff;
      rc_in     = accept ? 8'd0 : rc_ff;
      case (ctl.reg_op)
         leb_pkg::REG_INS: begin
            cursor_in = cursor_ff + leb_pkg::ptr_type'(1);
            end_in    = end_ff + leb_pkg::ptr_type'(1);
         end
         leb_pkg::REG_DEL: begin
            end_in = end_ff - leb_pkg::ptr_type'(n_x);
         end
         leb_pkg::REG_FWD: begin
            cursor_in = cursor_ff + leb_pkg::ptr_type'(n_x);
         end
         leb_pkg::REG_BWD: begin
            cursor_in = cursor_ff - leb_pkg::ptr_type'(n_x);
         end
         leb_pkg::REG_TAKE: begin
            rc_in = ram_rdata;
         end
         default: begin
            cursor_in = cursor_ff;
         end
      endcase
   end

   always_comb begin
      if (respond) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= leb_pkg::S_IDLE;
         cursor_ff    <= '0;
         end_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cursor_ff    <= cursor_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         char_ff  <= req_char_in;
         count_ff <= req_count;
         index_ff <= req_index;
      end
      if (ctl.dispatch) begin
         ok_ff <= ok;
      end
      ptr_ff <= ptr_in;
      rc_ff  <= rc_in;
      if (respond) begin
         rsp_status_ff <= ~ok_ff;
         rsp_cursor_ff <= cur_x[7:0];
         rsp_end_ff    <= end_x[7:0];
         rsp_char_ff   <= rc_ff;
      end
   end

   leb_ram #(
      .WIDTH (8),
      .DEPTH (leb_pkg::LINE_SIZE)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_beep       = rsp_status_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_end_pos    = rsp_end_ff;
   assign rsp_read_char  = rsp_char_ff;

   // The cursor never passes the end of the line.
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= end_ff)
      else $error("cursor beyond line end");

   // The line never grows past its usable capacity.
   a_end_in_capacity: assert property (@(posedge clock) disable iff (reset)
      end_x <= leb_pkg::cmp_type'(leb_pkg::LINE_SIZE - 1))
      else $error("line end beyond capacity");

   // The store is never written while the sequencer waits for an item.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == leb_pkg::S_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // An accepted item is decoded in the next cycle.
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff == leb_pkg::S_DECODE))
      else $error("accepted item not decoded");

   // A new result appears only from the answer step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff == leb_pkg::S_RESP))
      else $error("result raised outside the answer step");

endmodule

@@ tb/line_edit_checker.sv @@
// Checker for the line edit buffer: predicts every result and compares it with the block.
`timescale 1ns / 1ps
module line_edit_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_count,
   input  logic [7:0] req_index,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_status,
   input  logic       rsp_beep,
   input  logic [7:0] rsp_cursor_pos,
   input  logic [7:0] rsp_end_pos,
   input  logic [7:0] rsp_read_char,
   output int         fail_count,
   output int         pending
);

   typedef struct {
      logic       status;
      logic       beep;
      logic [7:0] cursor_pos;
      logic [7:0] end_pos;
      logic [7:0] read_char;
   } edit_result_type;

   logic [7:0]      line_chars [leb_pkg::LINE_SIZE];
   int              edit_cursor = 0;
   int              edit_end    = 0;
   int              mismatches  = 0;
   edit_result_type due_results [$];

   // Applies one item to the shadow line and returns the result it should give.
   function automatic edit_result_type apply_edit(input logic [2:0] kind,
                                                  input logic [7:0] char_in,
                                                  input logic [7:0] count,
                                                  input logic [7:0] index);
      edit_result_type r;
      logic            ok;
      int              n;
      int              i;
      n           = int'(count);
      ok          = 1'b0;
      r.read_char = 8'h00;
      case (kind)
         leb_pkg::KIND_INSERT: begin
            if (edit_end < leb_pkg::LINE_SIZE - 1) begin
               for (i = edit_end; i > edit_cursor; i--)
                  line_chars[i] = line_chars[i - 1];
               line_chars[edit_cursor] = char_in;
               edit_end++;
               edit_cursor++;
               ok = 1'b1;
            end
         end
         leb_pkg::KIND_DELETE: begin
            if (n != 0 && n <= edit_end - edit_cursor) begin
               for (i = edit_cursor; i + n < edit_end; i++)
                  line_chars[i] = line_chars[i + n];
               edit_end -= n;
               ok = 1'b1;
            end
         end
         leb_pkg::KIND_FORWARD: begin
            if (n != 0 && n <= edit_end - edit_cursor) begin
               edit_cursor += n;
               ok = 1'b1;
            end
         end
         leb_pkg::KIND_BACKWARD: begin
            if (n != 0 && n <= edit_cursor) begin
               edit_cursor -= n;
               ok = 1'b1;
            end
         end
         leb_pkg::KIND_READ: begin
            if (int'(index) < edit_end) begin
               r.read_char = line_chars[index];
               ok = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      r.status     = !ok;
      r.beep       = !ok;
      r.cursor_pos = edit_cursor[7:0];
      r.end_pos    = edit_end[7:0];
      return r;
   endfunction

   task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      edit_result_type want;
      if (reset) begin
         edit_cursor = 0;
         edit_end    = 0;
         due_results.delete();
      end else begin
         // Results first: a result never belongs to the item accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none expected, status %h cursor %h end %h",
                           $time, rsp_status, rsp_cursor_pos, rsp_end_pos);
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status)
                  report("status", 8'(want.status), 8'(rsp_status));
               if (rsp_beep !== want.beep)
                  report("beep", 8'(want.beep), 8'(rsp_beep));
               if (rsp_cursor_pos !== want.cursor_pos)
                  report("cursor_pos", want.cursor_pos, rsp_cursor_pos);
               if (rsp_end_pos !== want.end_pos)
                  report("end_pos", want.end_pos, rsp_end_pos);
               if (rsp_read_char !== want.read_char)
                  report("read_char", want.read_char, rsp_read_char);
            end
         end
         if (req_valid && !req_stall)
            due_results.push_back(apply_edit(req_kind, req_char_in, req_count, req_index));
      end
      fail_count <= mismatches;
      pending    <= due_results.size();
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the line edit buffer: request stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;

   localparam int HALF_PERIOD = 5;
   // Directed items come first, then roughly 900 random ones.
   localparam int TOTAL_ITEMS = 925;
   // The last stretch of the run has no idling on either side.
   localparam int QUIET_TAIL  = 100;
   // The long receiver hold outlasts the slowest item, so the sender is
   // certainly left waiting on a stalled input.
   localparam int LONG_HOLD   = 2 * leb_pkg::LINE_SIZE + 64;
   // The limit allows several times the slowest correct run, which is about
   // 925 items of a full-length shift plus the worst gaps on both sides.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Kinds from this value up are not defined and must be rejected.
   localparam int KIND_COUNT  = 5;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_kind;
   logic [7:0] req_char_in;
   logic [7:0] req_count;
   logic [7:0] req_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_status;
   logic       rsp_beep;
   logic [7:0] rsp_cursor_pos;
   logic [7:0] rsp_end_pos;
   logic [7:0] rsp_read_char;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int items_sent  = 0;

   // A rough picture of the cursor and the line length, kept only so that
   // the stimulus can aim its counts and indexes at legal or illegal values.
   int plan_cursor = 0;
   int plan_end    = 0;

   // Idling switches; the receiver's are written with nonblocking
   // assignments since its own process samples them at the clock edge.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_asks   = 0;

   always #(HALF_PERIOD) clock = ~clock;

   line_edit_buffer_unit i_dut (.*);

   line_edit_checker i_checker (.*);

   // Timeout guard: the run is failed if it is still going at the limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver side. It stalls in short random bursts while idling is on,
   // and when the top asks for it, it holds the result channel for the long
   // hold, so that the block backs up onto its input.
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Keeps the rough cursor and line length in step with an accepted item.
   function automatic void follow_plan(input logic [2:0] kind, input logic [7:0] count);
      int n;
      n = int'(count);
      case (kind)
         leb_pkg::KIND_INSERT: begin
            if (plan_end < leb_pkg::LINE_SIZE - 1) begin
               plan_end++;
               plan_cursor++;
            end
         end
         leb_pkg::KIND_DELETE: begin
            if (n != 0 && n <= plan_end - plan_cursor)
               plan_end -= n;
         end
         leb_pkg::KIND_FORWARD: begin
            if (n != 0 && n <= plan_end - plan_cursor)
               plan_cursor += n;
         end
         leb_pkg::KIND_BACKWARD: begin
            if (n != 0 && n <= plan_cursor)
               plan_cursor -= n;
         end
         default: begin
         end
      endcase
   endfunction

   // Offers one item and returns at the edge where it is accepted. Valid is
   // left high, so back-to-back items follow without a gap unless the next
   // call chooses one; a stalled payload is never touched.
   task automatic send_item(input logic [2:0] kind, input logic [7:0] char_in,
                            input logic [7:0] count, input logic [7:0] index);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_char_in <= char_in;
      req_count   <= count;
      req_index   <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      follow_plan(kind, count);
      items_sent++;
   endtask

   // Lowers valid and waits until every expected result has come back. The
   // first edge lets the count of outstanding results catch up with the
   // item that was accepted last.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // A legal count from 1 to most, usually a short one.
   function automatic logic [7:0] pick_count(input int most);
      if (most > 8 && $urandom_range(0, 3) != 0)
         return 8'($urandom_range(1, 8));
      return 8'($urandom_range(1, most));
   endfunction

   // A run of single-character inserts, as a pasted string arrives.
   task automatic type_text();
      int n;
      n = $urandom_range(1, 24);
      repeat (n) send_item(leb_pkg::KIND_INSERT, rand_byte(), rand_byte(), rand_byte());
   endtask

   // Legal cursor moves, deletes and reads with random content, or an insert on an empty line.
   task automatic wander();
      int n;
      int tail;
      int pick;
      n = $urandom_range(2, 8);
      repeat (n) begin
         tail = plan_end - plan_cursor;
         pick = $urandom_range(0, 3);
         if (pick == 0 && tail > 0)
            send_item(leb_pkg::KIND_FORWARD, rand_byte(), pick_count(tail), rand_byte());
         else if (pick == 1 && plan_cursor > 0)
            send_item(leb_pkg::KIND_BACKWARD, rand_byte(), pick_count(plan_cursor),
                      rand_byte());
         else if (pick == 2 && tail > 0)
            send_item(leb_pkg::KIND_DELETE, rand_byte(), pick_count(tail), rand_byte());
         else if (plan_end > 0)
            send_item(leb_pkg::KIND_READ, rand_byte(), rand_byte(),
                      8'($urandom_range(0, plan_end - 1)));
         else
            send_item(leb_pkg::KIND_INSERT, rand_byte(), rand_byte(), rand_byte());
      end
   endtask

   // Backs the cursor up and cuts a stretch out, which keeps the line from
   // filling up and gives long left shifts.
   task automatic trim();
      if (plan_cursor > 0)
         send_item(leb_pkg::KIND_BACKWARD, rand_byte(), 8'($urandom_range(1, plan_cursor)),
                   rand_byte());
      if (plan_end > plan_cursor)
         send_item(leb_pkg::KIND_DELETE, rand_byte(),
                   8'($urandom_range(1, plan_end - plan_cursor)), rand_byte());
   endtask

   // Broken requests: zero counts, counts past the tail or the head, reads
   // at or past the end, and plain noise that includes the undefined kinds.
   task automatic misuse();
      int tail;
      tail = plan_end - plan_cursor;
      case ($urandom_range(0, 4))
         0: send_item(3'($urandom_range(leb_pkg::KIND_DELETE, leb_pkg::KIND_BACKWARD)),
                      rand_byte(), 8'h00, rand_byte());
         1: if (tail < 255)
               send_item($urandom_range(0, 1) ? leb_pkg::KIND_DELETE : leb_pkg::KIND_FORWARD,
                         rand_byte(), 8'($urandom_range(tail + 1, 255)), rand_byte());
         2: if (plan_cursor < 255)
               send_item(leb_pkg::KIND_BACKWARD, rand_byte(),
                         8'($urandom_range(plan_cursor + 1, 255)), rand_byte());
         3: if (plan_end <= 255)
               send_item(leb_pkg::KIND_READ, rand_byte(), rand_byte(),
                         8'($urandom_range(plan_end, 255)));
         default: send_item(3'($urandom_range(0, 7)), rand_byte(), rand_byte(), rand_byte());
      endcase
   endtask

   // Moves to the end of the line and types until it is full, then tries a
   // few more characters, which the full line must turn away. The largest
   // moves and the last readable position are exercised while it is full.
   task automatic fill_line();
      if (plan_end > plan_cursor)
         send_item(leb_pkg::KIND_FORWARD, rand_byte(), 8'(plan_end - plan_cursor), rand_byte());
      while (plan_end < leb_pkg::LINE_SIZE - 1)
         send_item(leb_pkg::KIND_INSERT, rand_byte(), rand_byte(), rand_byte());
      repeat (3) send_item(leb_pkg::KIND_INSERT, rand_byte(), rand_byte(), rand_byte());
      send_item(leb_pkg::KIND_READ, rand_byte(), rand_byte(), 8'(leb_pkg::LINE_SIZE - 2));
      send_item(leb_pkg::KIND_BACKWARD, rand_byte(), 8'(plan_cursor), rand_byte());
      send_item(leb_pkg::KIND_FORWARD, rand_byte(), 8'(plan_end), rand_byte());
      trim();
   endtask

   initial begin
      bit held;
      bit paused;
      bit filled;
      int k;
      held   = 1'b0;
      paused = 1'b0;
      filled = 1'b0;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_kind    <= leb_pkg::KIND_INSERT;
      req_char_in <= 8'h00;
      req_count   <= 8'h00;
      req_index   <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the empty line every read, delete and move is
      // out of bounds.
      send_item(leb_pkg::KIND_READ, 8'h00, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_DELETE, 8'h00, 8'h01, 8'h00);
      send_item(leb_pkg::KIND_FORWARD, 8'h00, 8'h01, 8'h00);
      send_item(leb_pkg::KIND_BACKWARD, 8'h00, 8'h01, 8'h00);
      // Extreme characters typed at the end of the line.
      send_item(leb_pkg::KIND_INSERT, 8'h00, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_INSERT, 8'hFF, 8'hFF, 8'hFF);
      send_item(leb_pkg::KIND_INSERT, 8'h80, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_INSERT, 8'h7F, 8'h00, 8'h00);
      // A zero count is rejected for delete and both moves.
      send_item(leb_pkg::KIND_DELETE, 8'h00, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_FORWARD, 8'h00, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_BACKWARD, 8'h00, 8'h00, 8'h00);
      // An insert in the middle shifts the tail right.
      send_item(leb_pkg::KIND_BACKWARD, 8'h00, 8'h03, 8'h00);
      send_item(leb_pkg::KIND_INSERT, 8'h55, 8'h00, 8'h00);
      // Reads of the first and last characters, then at and past the end.
      send_item(leb_pkg::KIND_READ, 8'h00, 8'h00, 8'h00);
      send_item(leb_pkg::KIND_READ, 8'h00, 8'h00, 8'h04);
      send_item(leb_pkg::KIND_READ, 8'h00, 8'h00, 8'h05);
      send_item(leb_pkg::KIND_READ, 8'h00, 8'h00, 8'hFF);
      // Largest counts, beyond both the tail and the head.
      send_item(leb_pkg::KIND_FORWARD, 8'h00, 8'hFF, 8'h00);
      send_item(leb_pkg::KIND_BACKWARD, 8'h00, 8'hFF, 8'h00);
      // A delete in the middle shifts the tail left.
      send_item(leb_pkg::KIND_DELETE, 8'h00, 8'h02, 8'h00);
      // The undefined kinds change nothing.
      for (k = KIND_COUNT; k < 8; k++)
         send_item(3'(k), 8'hFF, 8'hFF, 8'hFF);
      // Back to the start and delete the whole line.
      send_item(leb_pkg::KIND_BACKWARD, 8'h00, 8'h02, 8'h00);
      send_item(leb_pkg::KIND_DELETE, 8'h00, 8'h03, 8'h00);

      // Random part, built from short sequences.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) begin
            req_idle_on = 1'b0;
            rsp_idle_on <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            req_idle_on = 1'($urandom_range(0, 1));
            rsp_idle_on <= 1'($urandom_range(0, 1));
         end

         // Once, the receiver holds off for a long stretch while items keep
         // being offered without gaps.
         if (!held && items_sent >= 300) begin
            held        = 1'b1;
            req_idle_on = 1'b0;
            hold_asks   <= hold_asks + 1;
         end

         // Once, the sender pauses until the block has answered everything.
         if (!paused && items_sent >= 600) begin
            paused = 1'b1;
            drain();
         end

         if (!filled && items_sent >= 450) begin
            filled = 1'b1;
            fill_line();
         end else if (plan_end > 160 && $urandom_range(0, 1) == 1) begin
            trim();
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: type_text();
               4, 5, 6, 7: wander();
               default:    misuse();
            endcase
         end
      end

      // Wait for the last results, then allow for one more full shift in
      // case anything stray comes out.
      drain();
      repeat (leb_pkg::LINE_SIZE + 8) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/leb_pkg.sv
src/leb_ram.sv
src/line_edit_buffer_unit.sv
tb/line_edit_checker.sv
tb/tb_top.sv
